// ----- hdl/tdpt_pkg.sv -----
// Shared types and constants for the trial division prime test.
// Used by tdpt_ctrl, tdpt_dpath and trial_division_prime_test; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tdpt_pkg;

  localparam int NUM_WIDTH_DEF = 32;

  typedef logic [2:0] res_t;

  localparam res_t RES_BELOW = 3'd0;
  localparam res_t RES_TWO   = 3'd1;
  localparam res_t RES_EVEN  = 3'd2;
  localparam res_t RES_PRIME = 3'd3;
  localparam res_t RES_FOUND = 3'd4;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic div_next;
    logic out_load;
    res_t res;
  } cmd_t;

  typedef struct packed {
    logic below_two;
    logic even;
    logic is_two;
    logic div_last;
    logic div_over;
    logic rem_zero;
  } status_t;

endpackage

`default_nettype wire

// ----- hdl/tdpt_dpath.sv -----
// Datapath: candidate and divisor registers, bit-serial restoring divider,
// result registers. Depends on tdpt_pkg; driven by tdpt_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module tdpt_dpath
  import tdpt_pkg::*;
#(
  parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic [NUM_WIDTH-1:0] candidate,
  input  wire cmd_t                 cmd,
  output status_t                   sts,
  output logic                      is_prime,
  output logic [NUM_WIDTH-1:0]      factor,
  output logic [NUM_WIDTH-1:0]      cofactor,
  output logic                      below_two
);

  localparam int CNT_W = (NUM_WIDTH > 1) ? $clog2(NUM_WIDTH) : 1;

  logic [NUM_WIDTH-1:0] held_candidate;
  logic [NUM_WIDTH-1:0] trial_divisor;
  logic [NUM_WIDTH-1:0] work;               // dividend bits out, quotient bits in
  logic [NUM_WIDTH-1:0] partial_remainder;
  logic [CNT_W-1:0]     count;

  logic [NUM_WIDTH:0]   rem_shift;
  logic [NUM_WIDTH:0]   rem_diff;
  logic                 rem_ge;

  always_comb begin
    rem_shift = {partial_remainder, work[NUM_WIDTH-1]};
    rem_diff  = rem_shift - {1'b0, trial_divisor};
    rem_ge    = (rem_shift >= {1'b0, trial_divisor});
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      held_candidate <= candidate;
    end
    if (cmd.div_start || cmd.div_next) begin
      trial_divisor     <= cmd.div_start ? NUM_WIDTH'(3) : trial_divisor + NUM_WIDTH'(2);
      work              <= held_candidate;
      partial_remainder <= '0;
      count             <= '0;
    end else if (cmd.div_step) begin
      work              <= {work[NUM_WIDTH-2:0], rem_ge};
      partial_remainder <= rem_ge ? rem_diff[NUM_WIDTH-1:0] : rem_shift[NUM_WIDTH-1:0];
      count             <= count + CNT_W'(1);
    end
    if (cmd.out_load) begin
      is_prime  <= (cmd.res == RES_TWO) || (cmd.res == RES_PRIME);
      below_two <= (cmd.res == RES_BELOW);
      case (cmd.res)
        RES_EVEN: begin
          factor   <= NUM_WIDTH'(2);
          cofactor <= held_candidate >> 1;
        end
        RES_FOUND: begin
          factor   <= trial_divisor;
          cofactor <= work;
        end
        default: begin
          factor   <= '0;
          cofactor <= '0;
        end
      endcase
    end
  end

  always_comb begin
    sts.below_two = (held_candidate[NUM_WIDTH-1:1] == '0);
    sts.even      = ~held_candidate[0];
    sts.is_two    = (held_candidate == NUM_WIDTH'(2));
    sts.div_last  = (count == CNT_W'(NUM_WIDTH - 1));
    // after a full division work holds the quotient
    sts.div_over  = (trial_divisor > work);
    sts.rem_zero  = (partial_remainder == '0);
  end

endmodule

`default_nettype wire

// ----- hdl/tdpt_ctrl.sv -----
// Controller state machine: request handshakes and sequencing of the
// trial divisions. Depends on tdpt_pkg; drives tdpt_dpath.
`timescale 1ns / 1ps
`default_nettype none

module tdpt_ctrl
  import tdpt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    s_tvalid,
  output logic         s_tready,
  output logic         m_tvalid,
  input  wire logic    m_tready,
  input  wire status_t sts,
  output cmd_t         cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLASS = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state, state_next;
  res_t       res_code, res_next;
  logic       slot_free;

  assign s_tready  = (state == S_IDLE);
  assign slot_free = ~m_tvalid | m_tready;

  always_comb begin
    state_next    = state;
    res_next      = res_code;
    cmd           = '0;
    cmd.res       = res_code;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_CLASS;
        end
      end
      S_CLASS: begin
        if (sts.below_two) begin
          res_next   = RES_BELOW;
          state_next = S_DONE;
        end else if (sts.even) begin
          res_next   = sts.is_two ? RES_TWO : RES_EVEN;
          state_next = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.div_over) begin
          res_next   = RES_PRIME;
          state_next = S_DONE;
        end else if (sts.rem_zero) begin
          res_next   = RES_FOUND;
          state_next = S_DONE;
        end else begin
          cmd.div_next = 1'b1;
          state_next   = S_DIV;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      res_code <= RES_BELOW;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      res_code <= res_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_accept_classify: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == S_CLASS)
    else $error("accepted request not followed by classification");

  a_eval_after_div: assert property (@(posedge clk) disable iff (rst)
    state == S_EVAL |-> $past(state) == S_DIV)
    else $error("evaluation without a finished division");

  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV && sts.div_last |=> state == S_EVAL)
    else $error("division ran past its last step");

  a_hold_done: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && m_tvalid && !m_tready |=> state == S_DONE && m_tvalid)
    else $error("result overwrote a request still waiting");

endmodule

`default_nettype wire

// ----- hdl/trial_division_prime_test.sv -----
// Top level of the trial division prime test: stream ports, controller and
// datapath. Depends on tdpt_pkg, tdpt_ctrl and tdpt_dpath.
//
// Channel | Direction | Handshake         | Payload
// --------+-----------+-------------------+----------------------------------
// s_      | in        | s_tvalid/s_tready | s_tdata: candidate
// m_      | out       | m_tvalid/m_tready | m_tdata: is_prime, factor,
//         |           |                   |          cofactor, below_two
//
// Sequence: a candidate below two or even goes from accept through classify
// to load output. An odd candidate runs k trials, where k is the number of
// odd divisors tried (up to about sqrt(candidate)/2); each trial is one pass
// of the bit-serial divider, one quotient bit per cycle, then an evaluation.
// Reset: synchronous, active high; returns the controller to idle and drops
// m_tvalid. One request is worked on at a time; s_tready is high only when
// idle, and a new request is accepted while the last result still waits.
// Stalls: a finished result waits for a free output register before it loads.
`timescale 1ns / 1ps
`default_nettype none

module trial_division_prime_test
  import tdpt_pkg::*;
#(
  parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   s_tvalid,
  output logic                                        s_tready,
  // [NUM_WIDTH-1:0] candidate, zero padded to whole bytes
  input  wire logic [((NUM_WIDTH+7)/8)*8-1:0]         s_tdata,
  output logic                                        m_tvalid,
  input  wire logic                                   m_tready,
  // [0] is_prime, [NUM_WIDTH:1] factor, [2*NUM_WIDTH:NUM_WIDTH+1] cofactor,
  // [2*NUM_WIDTH+1] below_two, zero padded to whole bytes
  output logic [((2*NUM_WIDTH+2+7)/8)*8-1:0]          m_tdata
);

  localparam int OUT_W = ((2*NUM_WIDTH+2+7)/8)*8;

  cmd_t                 cmd;
  status_t              sts;
  logic                 is_prime;
  logic                 below_two;
  logic [NUM_WIDTH-1:0] factor;
  logic [NUM_WIDTH-1:0] cofactor;

  // sequence the request through classify, divide and evaluate
  tdpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // hold the candidate, run the divider, form the result fields
  tdpt_dpath #(
    .NUM_WIDTH (NUM_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .candidate (s_tdata[NUM_WIDTH-1:0]),
    .cmd       (cmd),
    .sts       (sts),
    .is_prime  (is_prime),
    .factor    (factor),
    .cofactor  (cofactor),
    .below_two (below_two)
  );

  // pack result fields from the lowest bit up; pad bits stay zero
  assign m_tdata = OUT_W'({below_two, cofactor, factor, is_prime});

endmodule

`default_nettype wire
